@@ src/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, held off while rst is high
`define ASSERT_CLK_RST(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// concurrent check on an explicit clock and reset
`define ASSERT_ON(label, ck, rs, prop) \
  label: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("assertion failed");

`endif

@@ src/hbs_pkg.sv @@
// shared constants, command codes and remainder step for the hash set
package hbs_pkg;

  localparam int KEY_W      = 64;
  localparam int BUCKETS    = 256;
  localparam int WAYS       = 4;
  localparam int SLOTS      = BUCKETS * WAYS;
  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int CNT_W      = BKT_W + 1;
  localparam int WAY_W      = $clog2(WAYS);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int MODE_W     = 2;
  localparam int DIGIT_W    = 4;
  localparam int DIV_STEPS  = KEY_W / DIGIT_W;
  localparam int DIVC_W     = $clog2(DIV_STEPS);
  localparam int PDATA_W    = 32;
  localparam int PADDR_W    = 3;
  localparam int CFG_RESET  = BUCKETS;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_TEST  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // register index of bucket_count
  localparam logic REG_BUCKET_COUNT = 1'b0;

  // one digit of restoring remainder: DIGIT_W compare and subtract steps
  function automatic logic [BKT_W-1:0] rem_step(
    input logic [BKT_W-1:0]   rem_in,
    input logic [DIGIT_W-1:0] digit,
    input logic [CNT_W-1:0]   divisor
  );
    logic [BKT_W-1:0] r;
    logic [CNT_W-1:0] t;
    r = rem_in;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, digit[i]};
      if (t >= divisor) begin
        t = t - divisor;
      end
      r = t[BKT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/bucketed_hash_set_membership.sv @@
// hash set of signed 64-bit keys with floored modulo buckets and fixed ways
//
// input channel (in_valid/in_ready, mode, key): one transaction per command,
// add a key, test a key, or clear the whole set. output channel
// (out_valid/out_ready, found, bucket_full): exactly one result transaction
// per command, in command order.
// bucket_count is written over the apb port at byte address 0; a value of
// zero acts as 1, values above 256 act as 256. the user must write it only
// when idle; the block itself does not enforce it. an add or test goes from
// acceptance to out_valid through the remainder unit (4 key bits per cycle),
// a fold of negative keys, one valid-row read, a key read and a compare per
// way through the single key memory port and one 64-bit comparator, an update
// and a done state that loads the result once the output register is free.
// key zero and the unused mode go from acceptance straight to the done state.
// a clear walks the valid memory one bucket per cycle, then answers.
// after reset the same walk runs and in_ready stays low.
// in_ready is high only when the sequencer is idle; one command is in
// flight at a time. the result sits in an output register, so a stalled
// receiver does not stop the next command being accepted, only its finish.
`include "assert_macros.svh"

module bucketed_hash_set_membership (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hbs_pkg::MODE_W-1:0]          mode,
  input  logic signed [hbs_pkg::KEY_W-1:0]    key,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                found,
  output logic                                bucket_full,
  // apb configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hbs_pkg::PADDR_W-1:0]         paddr,
  input  logic [hbs_pkg::PDATA_W-1:0]         pwdata,
  output logic [hbs_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);
  import hbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_FOLD,
    ST_ROW,
    ST_KRD,
    ST_CMP,
    ST_UPD,
    ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic [CNT_W-1:0]  bucket_count;
  logic              cfg_wr;

  // command context
  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  mag;
  logic              neg;
  logic [CNT_W-1:0]  n_eff;
  logic [BKT_W-1:0]  rem;
  logic [DIVC_W-1:0] div_ctr;
  logic [BKT_W-1:0]  bucket;
  logic [WAY_W-1:0]  way;
  logic [WAY_W-1:0]  free_way;
  logic              have_free;
  logic              hit;
  logic              full_flag;
  logic [BKT_W-1:0]  clr_ctr;
  logic              clr_reply;

  // memories
  logic [WAYS-1:0]   valid_mem [BUCKETS];
  logic [KEY_W-1:0]  key_mem [SLOTS];
  logic [WAYS-1:0]   vrow;
  logic [KEY_W-1:0]  kdata;

  logic              vmem_we;
  logic [BKT_W-1:0]  vmem_waddr;
  logic [WAYS-1:0]   vmem_wdata;
  logic              vmem_re;
  logic              kmem_we;
  logic              kmem_re;
  logic [SLOT_W-1:0] kmem_addr;
  logic [WAYS-1:0]   vrow_set;
  logic              upd_write;
  logic [CNT_W-1:0]  n_in;
  logic [KEY_W-1:0]  mag_in;

  // ---------------------------------------------------------------------
  // apb register: one 9-bit register, no wait states
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= CNT_W'(CFG_RESET);
    end else if (cfg_wr) begin
      bucket_count <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BUCKET_COUNT) begin
      prdata = PDATA_W'(bucket_count);
    end
  end

  // ---------------------------------------------------------------------
  // command decode at acceptance
  // ---------------------------------------------------------------------
  assign in_ready = (state == ST_IDLE);

  // clamp the divisor to 1..BUCKETS
  always_comb begin
    if (bucket_count == '0) begin
      n_in = CNT_W'(1);
    end else if (bucket_count > CNT_W'(BUCKETS)) begin
      n_in = CNT_W'(BUCKETS);
    end else begin
      n_in = bucket_count;
    end
  end

  // magnitude of the key; the most negative key maps to 2^63, still correct
  assign mag_in = key[KEY_W-1] ? (KEY_W'(0) - KEY_W'(key)) : KEY_W'(key);

  // ---------------------------------------------------------------------
  // memory control
  // ---------------------------------------------------------------------
  assign upd_write = (mode_q == MODE_ADD) && !hit && have_free;

  always_comb begin
    vrow_set           = vrow;
    vrow_set[free_way] = 1'b1;
  end

  always_comb begin
    vmem_we    = 1'b0;
    vmem_waddr = bucket;
    vmem_wdata = vrow_set;
    vmem_re    = (state == ST_ROW);
    kmem_we    = (state == ST_UPD) && upd_write;
    kmem_re    = (state == ST_KRD);
    kmem_addr  = {bucket, way};
    if (state == ST_CLEAR) begin
      vmem_we    = 1'b1;
      vmem_waddr = clr_ctr;
      vmem_wdata = '0;
    end else if (state == ST_UPD) begin
      vmem_we    = upd_write;
      kmem_addr  = {bucket, free_way};
    end
  end

  // valid bits, one row of ways per bucket
  always_ff @(posedge clk) begin
    if (vmem_we) begin
      valid_mem[vmem_waddr] <= vmem_wdata;
    end
    if (vmem_re) begin
      vrow <= valid_mem[bucket];
    end
  end

  // stored keys, single port
  always_ff @(posedge clk) begin
    if (kmem_we) begin
      key_mem[kmem_addr] <= key_q;
    end
    if (kmem_re) begin
      kdata <= key_mem[kmem_addr];
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_ctr   <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result register: loaded when the command finishes, freed on handshake
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode_q    <= mode;
            key_q     <= KEY_W'(key);
            mag       <= mag_in;
            neg       <= key[KEY_W-1];
            n_eff     <= n_in;
            rem       <= '0;
            div_ctr   <= '0;
            way       <= '0;
            free_way  <= '0;
            have_free <= 1'b0;
            hit       <= 1'b0;
            full_flag <= 1'b0;
            if (mode == MODE_CLEAR) begin
              clr_ctr   <= '0;
              clr_reply <= 1'b1;
              state     <= ST_CLEAR;
            end else if ((mode == MODE_ADD || mode == MODE_TEST) && key != '0) begin
              state <= ST_DIV;
            end else begin
              // key zero and the unused mode answer with zeros
              state <= ST_DONE;
            end
          end
        end
        ST_CLEAR: begin
          clr_ctr <= clr_ctr + BKT_W'(1);
          if (clr_ctr == BKT_W'(BUCKETS - 1)) begin
            state <= clr_reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_DIV: begin
          // four key bits per cycle, most significant first
          rem     <= rem_step(rem, mag[KEY_W-1 -: DIGIT_W], n_eff);
          mag     <= mag << DIGIT_W;
          div_ctr <= div_ctr + DIVC_W'(1);
          if (div_ctr == DIVC_W'(DIV_STEPS - 1)) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          // floored modulo: a negative key with a nonzero remainder folds up
          if (neg && rem != '0) begin
            bucket <= BKT_W'(n_eff - CNT_W'(rem));
          end else begin
            bucket <= rem;
          end
          state <= ST_ROW;
        end
        ST_ROW: begin
          state <= ST_KRD;
        end
        ST_KRD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (vrow[way]) begin
            if (kdata == key_q) begin
              hit <= 1'b1;
            end
          end else if (!have_free) begin
            have_free <= 1'b1;
            free_way  <= way;
          end
          if (way == WAY_W'(WAYS - 1)) begin
            state <= ST_UPD;
          end else begin
            way   <= way + WAY_W'(1);
            state <= ST_KRD;
          end
        end
        ST_UPD: begin
          if (mode_q == MODE_ADD && !hit && !have_free) begin
            full_flag <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            found       <= hit;
            bucket_full <= full_flag;
            clr_reply   <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // one command in flight: acceptance closes the input side
  `ASSERT_CLK_RST(a_one_in_flight, (in_valid && in_ready) |=> !in_ready)
  // an add is either present already or dropped, never both
  `ASSERT_CLK_RST(a_found_xor_full, out_valid |-> !(found && bucket_full))
  // the clearing pass runs straight after reset
  `ASSERT_CLK_RST(a_reset_walk, $past(rst) |-> !in_ready)

endmodule

@@ tb/tb_bucketed_hash_set_membership.sv @@
// self-checking testbench for the bucketed hash set with floored modulo buckets
`timescale 1ns / 100ps

module tb_bucketed_hash_set_membership;
  import hbs_pkg::*;

  // run pacing
  localparam int unsigned SETTLE_CYCLES = 300;          // outlasts the clear walk
  localparam int unsigned HOLD_CYCLES   = 400;          // long receiver hold-off
  localparam int unsigned PHASE_ITEMS   = 110;
  localparam int unsigned POOL_DEPTH    = 24;
  localparam longint unsigned TIMEOUT_NS = 14_400_000;  // watchdog limit, 12 ns clock period

  // register map: index i at byte address 4*i, index 1 has no register behind it
  localparam logic [PADDR_W-1:0] ADDR_BUCKET_COUNT = PADDR_W'(REG_BUCKET_COUNT) << 2;
  localparam logic [PADDR_W-1:0] ADDR_SPARE        = PADDR_W'(4);

  // keys of note
  localparam logic [KEY_W-1:0] KEY_EMPTY = '0;
  localparam logic [KEY_W-1:0] KEY_MAX   = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic [KEY_W-1:0] KEY_MIN   = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [KEY_W-1:0] KEY_NEG1  = '1;

  // one command with the answer it must get
  typedef struct packed {
    mode_t            mode;
    logic [KEY_W-1:0] key;
    logic             found;
    logic             full;
  } membership_t;

  logic clk = 1'b0;
  logic rst;

  // command channel
  logic                     in_valid;
  logic                     in_ready;
  mode_t                    cmd_mode;
  logic signed [KEY_W-1:0]  cmd_key;

  // result channel
  logic out_valid;
  logic out_ready;
  logic found;
  logic bucket_full;

  // apb port
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // shadow of the set and of its register
  logic [KEY_W-1:0] shadow_keys [SLOTS];
  bit               shadow_used [SLOTS];
  logic [CNT_W-1:0] shadow_count;

  membership_t      awaited_answers[$];
  logic [KEY_W-1:0] key_pool[$];
  int unsigned      err_count;
  int unsigned      burst_left;
  bit               hold_request;

  bucketed_hash_set_membership dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (cmd_mode),
    .key         (cmd_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .bucket_full (bucket_full),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // count in use: zero behaves as one, anything past the table saturates
  function automatic int unsigned active_buckets();
    if (shadow_count == '0) begin
      return 1;
    end
    if (shadow_count > CNT_W'(BUCKETS)) begin
      return BUCKETS;
    end
    return int'(shadow_count);
  endfunction

  // floored remainder, so negative keys still land in 0..count-1
  function automatic int unsigned home_bucket(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] n;
    logic [KEY_W-1:0] r;
    n = KEY_W'(active_buckets());
    if (!k[KEY_W-1]) begin
      r = k % n;
    end else begin
      r = (KEY_W'(0) - k) % n;
      if (r != '0) begin
        r = n - r;
      end
    end
    return int'(r);
  endfunction

  // updates the shadow set and gives the answer the block owes for this command
  function automatic membership_t apply_command(input mode_t m, input logic [KEY_W-1:0] k);
    membership_t ans;
    int          base;
    int          spare;
    ans       = '0;
    ans.mode  = m;
    ans.key   = k;
    if (m == MODE_CLEAR) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    end else if ((m == MODE_ADD || m == MODE_TEST) && k != KEY_EMPTY) begin
      base  = home_bucket(k) * WAYS;
      spare = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (shadow_used[base + w]) begin
          if (shadow_keys[base + w] == k) ans.found = 1'b1;
        end else if (spare < 0) begin
          spare = base + w;
        end
      end
      // an add only lands if the key is new, and only if a way is free
      if (m == MODE_ADD && !ans.found) begin
        if (spare >= 0) begin
          shadow_keys[spare] = k;
          shadow_used[spare] = 1'b1;
        end else begin
          ans.full = 1'b1;
        end
      end
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // one command transaction; entered and left just after a falling edge
  task automatic send_item(input mode_t m, input logic [KEY_W-1:0] k);
    in_valid <= 1'b1;
    cmd_mode <= m;
    cmd_key  <= k;
    do @(posedge clk); while (!in_ready);
    // logged on the next falling edge so it never races a result on the same edge
    @(negedge clk);
    awaited_answers.push_back(apply_command(m, k));
  endtask

  // sender works in bursts; gaps are sometimes longer than a whole add
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // wait until every answer is in and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // only index zero holds a register, other addresses drop the write
    if ((addr >> 2) == PADDR_W'(REG_BUCKET_COUNT)) begin
      shadow_count = data[CNT_W-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // keys biased towards ones already seen so adds collide and tests hit
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               s;
    longint           q;
    int unsigned      roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && key_pool.size() != 0) begin
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    end
    case (roll)
      4: begin
        k = {$urandom, $urandom};
      end
      5: begin
        s = int'($urandom_range(0, 100)) - 50;
        k = {{32{s[31]}}, s};
      end
      6: begin
        // same bucket as many others: multiples of the count plus a small offset
        q = longint'(int'($urandom_range(0, 2000)) - 1000);
        k = q * longint'(active_buckets()) + longint'($urandom_range(0, 2));
      end
      7: begin
        k = $urandom_range(0, 1) ? KEY_MIN + KEY_W'($urandom_range(0, 3))
                                 : KEY_MAX - KEY_W'($urandom_range(0, 3));
      end
      default: begin
        k = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 1)) k = KEY_W'(0) - k;
      end
    endcase
    key_pool.push_back(k);
    if (key_pool.size() > POOL_DEPTH) key_pool.delete($urandom_range(0, POOL_DEPTH));
    return k;
  endfunction

  function automatic mode_t pick_mode();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 46) return MODE_ADD;
    if (roll < 92) return MODE_TEST;
    if (roll < 95) return MODE_CLEAR;
    return MODE_NOP;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: own stall pattern, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned tick;
    int unsigned style;
    out_ready = 1'b0;
    tick      = 0;
    style     = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        tick++;
        if (tick % 97 == 0) style = $urandom_range(0, 3);
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 7 < 4);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking: every result transaction against the oldest awaited answer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    membership_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_answers.size() == 0) begin
        $error("result transaction with no command outstanding");
        err_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0b, actual %0b (mode %0d, key %0d)",
                 want.found, found, want.mode, $signed(want.key));
          err_count++;
        end
        if (bucket_full !== want.full) begin
          $error("bucket_full: expected %0b, actual %0b (mode %0d, key %0d)",
                 want.full, bucket_full, want.mode, $signed(want.key));
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // largest and most negative keys, -1 and +1 (count at its reset value)
  task automatic test_extreme_keys();
    send_item(MODE_ADD, KEY_MAX);
    send_item(MODE_ADD, KEY_MIN);
    send_item(MODE_ADD, KEY_NEG1);
    send_item(MODE_ADD, KEY_W'(1));
    send_item(MODE_TEST, KEY_MAX);
    send_item(MODE_TEST, KEY_MIN);
    send_item(MODE_TEST, KEY_W'(2));
  endtask

  // the empty marker is never stored and never found
  task automatic test_key_zero();
    send_item(MODE_ADD, KEY_EMPTY);
    send_item(MODE_TEST, KEY_EMPTY);
  endtask

  // re-adding a stored key reports it present and keeps one copy
  task automatic test_duplicate_add();
    send_item(MODE_ADD, KEY_W'(1));
  endtask

  // top bucket already holds -1 and the largest key; two more fill it
  task automatic test_bucket_overflow();
    send_item(MODE_ADD, KEY_W'(511));
    send_item(MODE_ADD, KEY_W'(767));
    send_item(MODE_ADD, KEY_W'(1023));
    send_item(MODE_TEST, KEY_W'(1023));
  endtask

  task automatic test_clear_and_nop();
    send_item(MODE_CLEAR, KEY_MAX);
    send_item(MODE_TEST, KEY_W'(1));
    send_item(MODE_NOP, KEY_NEG1);
  endtask

  // count of zero, saturation, stale buckets after a change, write to a hole
  task automatic test_bucket_count_limits();
    settle();
    write_register(ADDR_BUCKET_COUNT, PDATA_W'(0));
    send_item(MODE_ADD, KEY_W'(3));
    send_item(MODE_ADD, KEY_W'(-5));
    send_item(MODE_TEST, KEY_W'(3));
    settle();
    write_register(ADDR_BUCKET_COUNT, PDATA_W'(511));
    // both keys sit in bucket zero, the new count looks elsewhere
    send_item(MODE_TEST, KEY_W'(-5));
    send_item(MODE_TEST, KEY_W'(3));
    settle();
    write_register(ADDR_SPARE, PDATA_W'(5));
    send_item(MODE_ADD, KEY_W'(261));
    send_item(MODE_TEST, KEY_W'(261));
  endtask

  task automatic test_random_traffic(input logic [PDATA_W-1:0] count_value,
                                     input int unsigned items, input bit steady);
    mode_t            m;
    logic [KEY_W-1:0] k;
    settle();
    write_register(ADDR_BUCKET_COUNT, count_value);
    if ($urandom_range(0, 3) == 0) write_register(ADDR_SPARE, {$urandom});
    burst_left = 0;
    repeat (items) begin
      m = pick_mode();
      k = pick_key();
      send_item(m, k);
      if (!steady) pace_sender();
    end
  endtask

  // receiver holds off while commands keep coming, so the input must stall
  task automatic test_backpressure();
    settle();
    hold_request = 1'b1;
    repeat (16) begin
      send_item($urandom_range(0, 1) ? MODE_ADD : MODE_TEST, pick_key());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd_mode     = MODE_NOP;
    cmd_key      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    err_count    = 0;
    burst_left   = 0;
    hold_request = 1'b0;
    shadow_count = CNT_W'(CFG_RESET);
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // reset runs a clearing walk first, settle covers it
    settle();
    test_extreme_keys();
    test_key_zero();
    test_duplicate_add();
    test_bucket_overflow();
    test_clear_and_nop();
    test_bucket_count_limits();

    test_random_traffic(PDATA_W'(256), PHASE_ITEMS, 1'b0);
    test_random_traffic(PDATA_W'(1), PHASE_ITEMS, 1'b0);
    test_random_traffic(PDATA_W'(0), PHASE_ITEMS, 1'b1);
    test_random_traffic(PDATA_W'(511), PHASE_ITEMS, 1'b0);
    test_random_traffic(PDATA_W'(2), PHASE_ITEMS, 1'b0);
    test_random_traffic(PDATA_W'(7), PHASE_ITEMS, 1'b1);
    test_random_traffic(PDATA_W'($urandom_range(1, 256)), PHASE_ITEMS, 1'b0);
    test_random_traffic(PDATA_W'(3), PHASE_ITEMS, 1'b0);
    test_random_traffic(PDATA_W'(256), PHASE_ITEMS, 1'b0);
    test_backpressure();

    // drain, then a quiet stretch so a stray extra result would still be seen
    settle();
    if (err_count == 0) begin
      $display("tb_bucketed_hash_set_membership OK");
    end else begin
      $display("tb_bucketed_hash_set_membership NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_bucketed_hash_set_membership NOT OK");
    $finish;
  end

endmodule
